/* rtl/linear_probe_hash_map_macros.svh */
// Assertion macros for the linear probe hash map checker.
// Included by the checker; depends on nothing else.
`ifndef LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define LPHM_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lphm check failed");
// Next-cycle implication checked outside reset.
`define LPHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lphm check failed");
`endif

/* rtl/lphm_pkg.sv */
// Package for the linear probe hash map: types, codes, sizes, hash constants.
// No dependencies.
package lphm_pkg;
   localparam int SLOTS_DEF = 256;
   localparam int VALUE_BITS_DEF = 32;
   localparam int KEY_BITS = 64;
   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   typedef enum logic [1:0] {OP_SET = 2'd0, OP_GET = 2'd1, OP_REMOVE = 2'd2,
                             OP_NOP = 2'd3} op_type;
   typedef enum logic [1:0] {ST_OK = 2'd0, ST_MISS = 2'd1, ST_FULL = 2'd2,
                             ST_RSVD = 2'd3} status_type;
   typedef enum logic [1:0] {MARK_EMPTY = 2'd0, MARK_LIVE = 2'd1, MARK_TOMB = 2'd2,
                             MARK_RSVD = 2'd3} mark_type;
   typedef enum logic [2:0] {S_IDLE, S_HASH, S_READ, S_CHECK, S_WRITE, S_RESP,
                             S_CLEAR} state_type;
endpackage

/* rtl/lphm_if.sv */
// Valid/ready channel interfaces for request and response.
// Depends on lphm_pkg.
interface lphm_req_if #(parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF);
   logic valid;
   logic ready;
   logic [1:0] opcode;
   logic [lphm_pkg::KEY_BITS-1:0] key;
   logic [VALUE_BITS-1:0] new_value;
   modport source (output valid, opcode, key, new_value, input ready);
   modport sink (input valid, opcode, key, new_value, output ready);
endinterface

interface lphm_rsp_if #(parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF);
   logic valid;
   logic ready;
   logic [1:0] status;
   logic is_new;
   logic [VALUE_BITS-1:0] read_value;
   modport source (output valid, status, is_new, read_value, input ready);
   modport sink (input valid, status, is_new, read_value, output ready);
endinterface

/* rtl/lphm_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module lphm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* rtl/lphm_hash.sv */
// Byte-serial FNV-1a hash unit: one xor and multiply per cycle.
// Depends on lphm_pkg.
module lphm_hash (
   input  logic clock,
   input  logic start,
   input  logic [lphm_pkg::KEY_BITS-1:0] key,
   output logic done,
   output logic [31:0] hash
);
   logic [31:0] hash_ff, hash_in;
   logic [lphm_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [31:0] mixed;

   assign mixed = hash_ff ^ {24'd0, key_ff[7:0]};

   always_comb begin
      hash_in = hash_ff;
      key_in = key_ff;
      cnt_in = cnt_ff;
      if (start) begin
         hash_in = lphm_pkg::FNV_OFFSET;
         key_in = key;
         cnt_in = 4'd8;
      end else if (cnt_ff != 4'd0) begin
         // advance one byte, least significant first
         hash_in = 32'(mixed * lphm_pkg::FNV_PRIME);
         key_in = key_ff >> 8;
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      key_ff <= key_in;
      cnt_ff <= cnt_in;
   end

   assign done = (cnt_ff == 4'd1);
   assign hash = hash_in;
endmodule

/* rtl/linear_probe_hash_map.sv */
// Linear probe hash map. Each request transfer (set, get, remove, no-op) is
// hashed with FNV-1a one key byte per cycle, then the slot store is walked
// one slot at a time (read, then compare) through its single RAM port,
// followed by a write step for a set or a remove hit, and a response step.
// The block takes one request at a time and is not ready while working.
// After reset a clearing pass marks all SLOTS slots empty, one per cycle,
// before the first request is taken. Sets refuse with full when a fresh
// slot would be taken at 3/4 load of the active size.
// Depends on lphm_pkg, lphm_if, lphm_ram, lphm_hash.
module linear_probe_hash_map #(
   parameter int SLOTS = lphm_pkg::SLOTS_DEF,
   parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   lphm_req_if.sink req,
   lphm_rsp_if.source rsp,
   input  logic csr_wr_en,
   input  logic [3:0] csr_wr_data
);
   localparam int AW = $clog2(SLOTS);
   localparam int CW = AW + 1;
   localparam int KB = lphm_pkg::KEY_BITS;
   localparam int EW = 2 + KB + VALUE_BITS;

   lphm_pkg::state_type state_ff, state_in;
   logic [3:0] size_ff;
   logic [1:0] op_ff;
   logic [KB-1:0] key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [AW-1:0] idx_ff, idx_in, tomb_ff, tomb_in;
   logic have_tomb_ff, have_tomb_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] used_ff, used_in, live_ff, live_in;
   logic [AW:0] clr_ff;
   logic [1:0] st_ff, st_in;
   logic new_ff, new_in;
   logic [VALUE_BITS-1:0] rd_ff, rd_in;
   logic found_ff, found_in;   // probe ended on a live slot holding the key, in idx

   // active slot mask
   logic [4:0] sz;
   logic [AW-1:0] mask;
   logic [CW:0] nslots;
   always_comb begin
      sz = {1'b0, size_ff};
      if (sz < 5'd3) sz = 5'd3;
      if (32'(sz) > AW) sz = 5'(AW);
      mask = AW'((32'd1 << sz) - 32'd1);
      nslots = (CW+1)'(32'd1 << sz);
   end

   // hash unit
   logic hash_done;
   logic [31:0] hash;
   lphm_hash u_hash (.clock(clock), .start(req.valid && req.ready), .key(req.key),
      .done(hash_done), .hash(hash));

   // slot store: {mark, key, value}
   logic ram_we;
   logic [AW-1:0] ram_addr;
   logic [EW-1:0] ram_wd, ram_rd;
   lphm_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (.clock(clock), .wr_en(ram_we),
      .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd));

   logic [1:0] rd_mark;
   logic [KB-1:0] rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   assign rd_mark = ram_rd[EW-1 -: 2];
   assign rd_key = ram_rd[VALUE_BITS +: KB];
   assign rd_val = ram_rd[VALUE_BITS-1:0];

   logic room;
   assign room = ({used_ff, 2'b00} < (CW+2)'(nslots * 3));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lphm_pkg::S_CLEAR: if (clr_ff == (AW+1)'(SLOTS - 1)) state_in = lphm_pkg::S_IDLE;
         lphm_pkg::S_IDLE: if (req.valid) state_in = lphm_pkg::S_HASH;
         lphm_pkg::S_HASH: begin
            if (hash_done) begin
               // skip the probe for a get or remove on an empty map, or a no-op
               if (op_ff == lphm_pkg::OP_NOP ||
                   (op_ff != lphm_pkg::OP_SET && live_ff == '0)) begin
                  state_in = lphm_pkg::S_RESP;
               end else begin
                  state_in = lphm_pkg::S_READ;
               end
            end
         end
         lphm_pkg::S_READ: state_in = lphm_pkg::S_CHECK;
         lphm_pkg::S_CHECK: begin
            if (rd_mark == lphm_pkg::MARK_LIVE && rd_key == key_ff) begin
               state_in = (op_ff == lphm_pkg::OP_GET) ? lphm_pkg::S_RESP : lphm_pkg::S_WRITE;
            end else if (rd_mark == lphm_pkg::MARK_EMPTY || cnt_ff == CW'(1)) begin
               state_in = (op_ff == lphm_pkg::OP_SET) ? lphm_pkg::S_WRITE : lphm_pkg::S_RESP;
            end else begin
               state_in = lphm_pkg::S_READ;
            end
         end
         lphm_pkg::S_WRITE: state_in = lphm_pkg::S_RESP;
         lphm_pkg::S_RESP: if (rsp.ready) state_in = lphm_pkg::S_IDLE;
         default: state_in = lphm_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   logic hit, fresh;
   always_comb begin
      idx_in = idx_ff;
      tomb_in = tomb_ff;
      have_tomb_in = have_tomb_ff;
      cnt_in = cnt_ff;
      used_in = used_ff;
      live_in = live_ff;
      st_in = st_ff;
      new_in = new_ff;
      rd_in = rd_ff;
      found_in = found_ff;
      ram_we = 1'b0;
      ram_addr = idx_ff;
      ram_wd = {lphm_pkg::MARK_LIVE, key_ff, val_ff};
      hit = rd_mark == lphm_pkg::MARK_LIVE && rd_key == key_ff;
      fresh = 1'b0;
      unique case (state_ff)
         lphm_pkg::S_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_ff[AW-1:0];
            ram_wd = {lphm_pkg::MARK_EMPTY, {(KB+VALUE_BITS){1'b0}}};
         end
         lphm_pkg::S_IDLE: begin
            st_in = lphm_pkg::ST_OK;
            new_in = 1'b0;
            rd_in = '0;
            have_tomb_in = 1'b0;
            found_in = 1'b0;
         end
         lphm_pkg::S_HASH: begin
            idx_in = hash[AW-1:0] & mask;
            cnt_in = nslots[CW-1:0];
            if (op_ff != lphm_pkg::OP_SET && op_ff != lphm_pkg::OP_NOP && live_ff == '0)
               st_in = lphm_pkg::ST_MISS;
         end
         lphm_pkg::S_READ: ;
         lphm_pkg::S_CHECK: begin
            if (hit) begin
               found_in = 1'b1;
               if (op_ff == lphm_pkg::OP_GET) rd_in = rd_val;
            end else begin
               if (rd_mark == lphm_pkg::MARK_TOMB && !have_tomb_ff) begin
                  have_tomb_in = 1'b1;
                  tomb_in = idx_ff;
               end
               if (rd_mark == lphm_pkg::MARK_EMPTY || cnt_ff == CW'(1)) begin
                  if (op_ff != lphm_pkg::OP_SET) st_in = lphm_pkg::ST_MISS;
                  // hold empty slot (or none) in idx, tomb separately
                  found_in = 1'b0;
                  fresh = rd_mark == lphm_pkg::MARK_EMPTY;
                  new_in = fresh; // marks that idx is an empty slot
               end else begin
                  idx_in = (idx_ff + AW'(1)) & mask;
                  cnt_in = cnt_ff - CW'(1);
               end
            end
         end
         lphm_pkg::S_WRITE: begin
            if (op_ff == lphm_pkg::OP_REMOVE) begin
               ram_we = 1'b1;
               ram_wd = {lphm_pkg::MARK_TOMB, key_ff, val_ff};
               if (live_ff != '0) live_in = live_ff - CW'(1);
            end else if (found_ff) begin
               ram_we = 1'b1;
               new_in = 1'b0;
            end else if (have_tomb_ff) begin
               ram_we = 1'b1;
               ram_addr = tomb_ff;
               live_in = live_ff + CW'(1);
               new_in = 1'b1;
            end else if (new_ff && room) begin
               ram_we = 1'b1;
               used_in = used_ff + CW'(1);
               live_in = live_ff + CW'(1);
               new_in = 1'b1;
            end else begin
               st_in = lphm_pkg::ST_FULL;
               new_in = 1'b0;
            end
         end
         lphm_pkg::S_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lphm_pkg::S_CLEAR;
         clr_ff <= '0;
         used_ff <= '0;
         live_ff <= '0;
         size_ff <= 4'd8;
      end else begin
         state_ff <= state_in;
         if (state_ff == lphm_pkg::S_CLEAR) clr_ff <= clr_ff + (AW+1)'(1);
         used_ff <= used_in;
         live_ff <= live_in;
         if (csr_wr_en) size_ff <= csr_wr_data;
      end
      if (req.valid && req.ready) begin
         op_ff <= req.opcode;
         key_ff <= req.key;
         val_ff <= req.new_value;
      end
      idx_ff <= idx_in;
      tomb_ff <= tomb_in;
      have_tomb_ff <= have_tomb_in;
      cnt_ff <= cnt_in;
      st_ff <= st_in;
      new_ff <= new_in;
      rd_ff <= rd_in;
      found_ff <= found_in;
   end

   assign req.ready = (state_ff == lphm_pkg::S_IDLE);
   assign rsp.valid = (state_ff == lphm_pkg::S_RESP);
   assign rsp.status = st_ff;
   assign rsp.is_new = new_ff && (op_ff == lphm_pkg::OP_SET);
   assign rsp.read_value = rd_ff;
endmodule

/* rtl/lphm_checker.sv */
// Port-level checker for the linear probe hash map, bound to the top level.
// Depends on lphm_pkg and linear_probe_hash_map_macros.svh.
`include "linear_probe_hash_map_macros.svh"
module lphm_checker #(
   parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_status,
   input logic rsp_is_new,
   input logic [VALUE_BITS-1:0] rsp_read_value
);
   // one request in flight: no acceptance while a response waits
   `LPHM_ASSERT(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // a transfer in drops ready, with no response valid, in the next cycle
   `LPHM_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready && !rsp_valid)
   // is_new only with status ok
   `LPHM_ASSERT(a_new_ok, clock, reset, rsp_valid && rsp_is_new, rsp_status == lphm_pkg::ST_OK)
   // a nonzero read value only with status ok and is_new low
   `LPHM_ASSERT(a_rd_ok, clock, reset, rsp_valid && rsp_read_value != '0, rsp_status == lphm_pkg::ST_OK && !rsp_is_new)
endmodule

bind linear_probe_hash_map lphm_checker #(.VALUE_BITS(VALUE_BITS)) u_lphm_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_is_new(rsp.is_new), .rsp_read_value(rsp.read_value));
